@@ src/sbs_pkg.sv @@
package sbs_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int LEN_W       = ADDR_W + 1;
  localparam int IDX_W       = ADDR_W + 2;
  localparam int DATA_W      = 32;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = LEN_W;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_LENGTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_MODE  = 2'd1;

  // stream payload widths
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 16;

  // input beat kinds
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    MODE_EXACT = 2'd0,
    MODE_LAST  = 2'd1,
    MODE_FIRST = 2'd2,
    MODE_NONE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_COMPARE,
    S_FINISH
  } ctrl_state_t;

  // controller to datapath
  typedef struct packed {
    logic wr;
    logic init;
    logic update;
    logic finish;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic more;
  } dp_stat_t;

endpackage

@@ src/sbs_ctrl.sv @@
module sbs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic                in_tuser,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  sbs_pkg::dp_stat_t   stat,
  output sbs_pkg::ctrl_cmd_t  cmd
);
  import sbs_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        in_beat;
  logic        slot_free;

  assign in_beat   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_beat && (in_tuser == CMD_SEARCH)) state_nxt = S_PROBE;
      end
      S_PROBE: begin
        state_nxt = stat.more ? S_COMPARE : S_FINISH;
      end
      S_COMPARE: begin
        state_nxt = S_PROBE;
      end
      S_FINISH: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        cmd.wr    = in_tvalid && (in_tuser == CMD_WRITE);
        cmd.init  = in_tvalid && (in_tuser == CMD_SEARCH);
      end
      S_PROBE: begin
      end
      S_COMPARE: begin
        cmd.update = 1'b1;
      end
      S_FINISH: begin
        cmd.finish = slot_free;
      end
      default: begin
      end
    endcase
  end

  // result slot valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.finish)      out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

`ifndef ASSERT_OFF
  a_cmp_after_probe: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COMPARE) |-> ($past(state_r) == S_PROBE))
    else $error("compare step not preceded by a probe");

  a_finish_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid_r || out_tready))
    else $error("result loaded over an untaken beat");

  a_valid_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(cmd.finish))
    else $error("result valid rose without a finished search");
`endif

endmodule

@@ src/sbs_dp.sv @@
module sbs_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sbs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sbs_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [sbs_pkg::ADDR_W-1:0]          in_position,
  input  logic signed [sbs_pkg::DATA_W-1:0]   in_entry_value,
  input  logic signed [sbs_pkg::DATA_W-1:0]   in_key,
  input  sbs_pkg::ctrl_cmd_t                  cmd,
  output sbs_pkg::dp_stat_t                   stat,
  output logic                                out_found,
  output logic [sbs_pkg::ADDR_W-1:0]          out_match_position
);
  import sbs_pkg::*;

  // configuration registers
  logic [LEN_W-1:0] length_r;
  mode_t            mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      length_r <= '0;
      mode_r   <= MODE_EXACT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TABLE_LENGTH: length_r <= cfg_data;
        REG_SEARCH_MODE:  mode_r   <= mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // search registers
  logic signed [IDX_W-1:0]  head_r, head_nxt;
  logic signed [IDX_W-1:0]  tail_r, tail_nxt;
  logic signed [IDX_W-1:0]  n_r, n_nxt;
  logic signed [DATA_W-1:0] key_r;
  mode_t                    run_mode_r;
  logic                     hit_r, hit_nxt;
  logic [ADDR_W-1:0]        hit_pos_r, hit_pos_nxt;
  logic                     found_r;
  logic [ADDR_W-1:0]        pos_r;

  // table memory
  logic [DATA_W-1:0]        mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] rd_data_r;
  logic [ADDR_W-1:0]        rd_addr;

  // clamped length
  logic [LEN_W-1:0] n_len;
  assign n_len = (length_r > LEN_W'(TABLE_DEPTH)) ? LEN_W'(TABLE_DEPTH) : length_r;
  assign n_nxt = $signed({1'b0, n_len});

  // midpoint, rounded up for the leading-run search
  logic signed [IDX_W:0]   mid_sum;
  logic signed [IDX_W-1:0] mid;
  assign mid_sum = $signed({head_r[IDX_W-1], head_r}) + $signed({tail_r[IDX_W-1], tail_r})
                 + $signed({{IDX_W{1'b0}}, (run_mode_r == MODE_LAST)});
  assign mid     = mid_sum[IDX_W:1];
  assign rd_addr = mid[ADDR_W-1:0];

  // loop condition
  always_comb begin
    case (run_mode_r)
      MODE_EXACT: stat.more = !hit_r && (head_r <= tail_r);
      MODE_LAST:  stat.more = head_r < tail_r;
      MODE_FIRST: stat.more = head_r < tail_r;
      default:    stat.more = 1'b0;
    endcase
  end

  // head and tail updates
  logic eq, lt;
  assign eq = rd_data_r == key_r;
  assign lt = rd_data_r < key_r;

  always_comb begin
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    hit_nxt     = hit_r;
    hit_pos_nxt = hit_pos_r;
    if (cmd.init) begin
      hit_nxt = 1'b0;
      case (mode_r)
        MODE_EXACT: begin
          head_nxt = '0;
          tail_nxt = n_nxt - IDX_W'(1);
        end
        MODE_LAST: begin
          head_nxt = -IDX_W'(1);
          tail_nxt = n_nxt - IDX_W'(1);
        end
        MODE_FIRST: begin
          head_nxt = '0;
          tail_nxt = n_nxt;
        end
        default: begin
          head_nxt = '0;
          tail_nxt = -IDX_W'(1);
        end
      endcase
    end else if (cmd.update) begin
      case (run_mode_r)
        MODE_EXACT: begin
          if (eq) begin
            hit_nxt     = 1'b1;
            hit_pos_nxt = mid[ADDR_W-1:0];
          end else if (lt) begin
            head_nxt = mid + IDX_W'(1);
          end else begin
            tail_nxt = mid - IDX_W'(1);
          end
        end
        MODE_LAST: begin
          if (eq) head_nxt = mid;
          else    tail_nxt = mid - IDX_W'(1);
        end
        MODE_FIRST: begin
          if (eq) tail_nxt = mid;
          else    head_nxt = mid + IDX_W'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r      <= 1'b0;
      run_mode_r <= MODE_NONE;
    end else begin
      hit_r <= hit_nxt;
      if (cmd.init) run_mode_r <= mode_r;
    end
  end

  always_ff @(posedge clk) begin
    head_r    <= head_nxt;
    tail_r    <= tail_nxt;
    hit_pos_r <= hit_pos_nxt;
    if (cmd.init) begin
      n_r   <= n_nxt;
      key_r <= in_key;
    end
  end

  // memory write and registered read
  always_ff @(posedge clk) begin
    if (cmd.wr) mem[in_position] <= in_entry_value;
    rd_data_r <= mem[rd_addr];
  end

  // result register
  logic              res_found;
  logic [ADDR_W-1:0] res_pos;

  always_comb begin
    res_found = 1'b0;
    res_pos   = '0;
    case (run_mode_r)
      MODE_EXACT: begin
        res_found = hit_r;
        res_pos   = hit_r ? hit_pos_r : '0;
      end
      MODE_LAST: begin
        res_found = head_r >= 0;
        res_pos   = (head_r >= 0) ? head_r[ADDR_W-1:0] : '0;
      end
      MODE_FIRST: begin
        res_found = head_r != n_r;
        res_pos   = (head_r != n_r) ? head_r[ADDR_W-1:0] : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      found_r <= res_found;
      pos_r   <= res_pos;
    end
  end

  assign out_found          = found_r;
  assign out_match_position = pos_r;

`ifndef ASSERT_OFF
  a_mid_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.update |-> ((mid >= 0) && (mid < n_r)))
    else $error("probe outside the searched range");

  a_last_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.finish && (run_mode_r == MODE_LAST) && (head_r >= 0)) |-> (head_r < n_r))
    else $error("leading-run result beyond length");

  a_init_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.init |=> ((tail_r <= n_r) && (head_r >= -IDX_W'(1))))
    else $error("search bounds set outside the table");
`endif

endmodule

@@ src/sorted_table_binary_search.sv @@
// Sorted table binary search.
// Input stream: a write beat (tuser = 0) stores entry_value at position in the
// table; a search beat (tuser = 1) looks for key among positions below
// table_length and produces one result beat {match_position, found}.
// Write beats give no result.
// Configuration: cfg_we with cfg_index 0 sets table_length (clamped to the
// table depth), index 1 sets search_mode (0 exact match in an ascending table,
// 1 last of a leading run of matches, 2 first of a trailing run, 3 none).
// A search: an accept step, then per table probe a probe state (address
// out, registered memory read) and a compare state, then a finish state;
// with 1024 entries at most 11 probes. One search is in flight at a time.
// The result sits in an output register: further beats are accepted while it
// waits, and a following search stalls only at its end until the result is
// taken. Reset clears the control state, the configuration and the result
// valid; table contents stay undefined until written.
module sorted_table_binary_search (
  input  logic                                clk,
  input  logic                                rst_n,
  // in_tdata: position[9:0], entry_value[41:10], key[73:42], zero fill
  input  logic [sbs_pkg::IN_TDATA_W-1:0]      in_tdata,
  // in_tuser: command
  input  logic                                in_tuser,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // out_tdata: found[0], match_position[10:1], zero fill
  output logic [sbs_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  input  logic                                cfg_we,
  input  logic [sbs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sbs_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sbs_pkg::*;

  ctrl_cmd_t         cmd;
  dp_stat_t          stat;
  logic              found;
  logic [ADDR_W-1:0] match_position;

  sbs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  sbs_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_position        (in_tdata[ADDR_W-1:0]),
    .in_entry_value     ($signed(in_tdata[ADDR_W+DATA_W-1:ADDR_W])),
    .in_key             ($signed(in_tdata[ADDR_W+2*DATA_W-1:ADDR_W+DATA_W])),
    .cmd                (cmd),
    .stat               (stat),
    .out_found          (found),
    .out_match_position (match_position)
  );

  // result beat packing
  assign out_tdata = {{(OUT_TDATA_W-ADDR_W-1){1'b0}}, match_position, found};

endmodule
